>>> hw/rtl/fpd_pkg.sv
package fpd_pkg;

	localparam int NOW_W      = 32;
	localparam int ALT_W      = 17;
	localparam int RATE_W     = 20;
	localparam int THR_W      = 16;
	localparam int JUMP_W     = 17;
	localparam int MS_W       = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int CMP_W      = RATE_W + 1;
	localparam int PROD_W     = ALT_W + 16;
	localparam int DIV_STEPS  = PROD_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic [15:0]       RATE_SCALE_MS = 16'd60000;
	localparam logic [RATE_W-1:0] RATE_MAX      = 20'h7FFFF;
	localparam logic [RATE_W-1:0] RATE_MIN      = 20'h80000;
	localparam logic [PROD_W-1:0] RATE_POS_LIM  = 33'd524287;
	localparam logic [PROD_W-1:0] RATE_NEG_LIM  = 33'd524288;

	localparam logic [THR_W-1:0]  CLIMB_THR_RST     = 16'd300;
	localparam logic [JUMP_W-1:0] JUMP_THR_RST      = 17'h1F830;
	localparam logic [THR_W-1:0]  LAND_THR_RST      = 16'd100;
	localparam logic [MS_W-1:0]   LANDED_HOLD_RST   = 20'd30000;
	localparam logic [MS_W-1:0]   RATE_INTERVAL_RST = 20'd10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLIMB_THR     = 3'd0,
		CFG_JUMP_THR      = 3'd1,
		CFG_LAND_THR      = 3'd2,
		CFG_LANDED_HOLD   = 3'd3,
		CFG_RATE_INTERVAL = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_FLIGHT = 2'd1,
		PH_JUMP   = 2'd2,
		PH_LANDED = 2'd3
	} phase_t;

	typedef struct packed {
		logic             start;
		logic             neg;
		logic [ALT_W-1:0] mag;
		logic [NOW_W-1:0] elapsed;
	} fpd_rate_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [RATE_W-1:0] rate;
	} fpd_rate_rsp_t;

endpackage

>>> hw/rtl/fpd_rate_unit.sv
module fpd_rate_unit import fpd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  fpd_rate_req_t req,
	output fpd_rate_rsp_t rsp
);

	typedef enum logic [3:0] {
		U_IDLE = 4'b0001,
		U_MUL  = 4'b0010,
		U_DIV  = 4'b0100,
		U_SAT  = 4'b1000
	} ustate_t;

	ustate_t             state_q;
	logic [STEP_W-1:0]   cnt_q;
	logic                neg_q;
	logic [ALT_W-1:0]    mag_q;
	logic [NOW_W-1:0]    divisor_q;
	logic [PROD_W-1:0]   dq_q;
	logic [NOW_W-1:0]    rem_q;

	logic [PROD_W-1:0]   product;
	logic [NOW_W:0]      rem_sh;
	logic [NOW_W:0]      rem_sub;
	logic                fits;
	logic [NOW_W-1:0]    rem_nx;
	logic [RATE_W-1:0]   rate_sat;

	assign product = PROD_W'(mag_q) * PROD_W'(RATE_SCALE_MS);
	assign rem_sh  = {rem_q, dq_q[PROD_W-1]};
	assign rem_sub = rem_sh - {1'b0, divisor_q};
	assign fits    = rem_sh >= {1'b0, divisor_q};
	assign rem_nx  = fits ? rem_sub[NOW_W-1:0] : rem_sh[NOW_W-1:0];

	always_comb begin
		if (neg_q) begin
			rate_sat = (dq_q > RATE_NEG_LIM) ? RATE_MIN : RATE_W'(~dq_q[RATE_W-1:0] + 1'b1);
		end else begin
			rate_sat = (dq_q > RATE_POS_LIM) ? RATE_MAX : dq_q[RATE_W-1:0];
		end
	end

	assign rsp.done = (state_q == U_SAT);
	assign rsp.rate = $signed(rate_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				U_IDLE: begin
					if (req.start) begin
						state_q <= U_MUL;
					end
				end
				U_MUL: begin
					cnt_q   <= '0;
					state_q <= U_DIV;
				end
				U_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= U_SAT;
					end
				end
				U_SAT: begin
					state_q <= U_IDLE;
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == U_IDLE && req.start) begin
			neg_q     <= req.neg;
			mag_q     <= req.mag;
			divisor_q <= req.elapsed;
		end
		if (state_q == U_MUL) begin
			dq_q  <= product;
			rem_q <= '0;
		end else if (state_q == U_DIV) begin
			dq_q  <= {dq_q[PROD_W-2:0], fits};
			rem_q <= rem_nx;
		end
	end

endmodule

>>> hw/rtl/flight_phase_detector.sv
// flight phase detector
// input channel (in_valid/in_ready): one transfer per sample, now_ms is a free
// running millisecond clock, altitude_ft a signed pressure altitude in feet.
// output channel (out_valid/out_ready): one result per sample with phase, climb
// rate, rate_updated flag, latched ground altitude and log start/stop strobes.
// config port: cfg_we writes cfg_data into register cfg_index (0 climb
// threshold, 1 jump threshold, 2 land threshold, 3 landed hold, 4 rate
// interval); other indexes are ignored. write only while the block is idle.
// timing: a sample that does not re-estimate the climb rate is registered as
// a result once the output register is free, and the next sample can be taken
// after that. a re-estimate first runs a multiply and a 33 step restoring
// divider, so its result and the next transfer come after the divider ends.
// in_ready is low while a sample is in work.
// if the receiver stalls, the result holds in the output register; the next
// sample is still taken, and its result waits until the register frees.
// reset: all thresholds return to their defaults, phase goes to wait, the climb
// rate to 0 and the first re-estimate only primes the stored altitude.
module flight_phase_detector import fpd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [NOW_W-1:0]         now_ms,
	input  logic signed [ALT_W-1:0]  altitude_ft,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               phase,
	output logic signed [RATE_W-1:0] climb_rate_fpm,
	output logic                     rate_updated,
	output logic signed [ALT_W-1:0]  ground_altitude_ft,
	output logic                     log_start,
	output logic                     log_stop
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CALC = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t                   state_q;
	logic [THR_W-1:0]         climb_thr_q;
	logic [JUMP_W-1:0]        jump_thr_q;
	logic [THR_W-1:0]         land_thr_q;
	logic [MS_W-1:0]          landed_hold_q;
	logic [MS_W-1:0]          rate_int_q;

	phase_t                   phase_q;
	logic signed [RATE_W-1:0] climb_rate_q;
	logic                     hold_active_q;
	logic [NOW_W-1:0]         hold_rem_q;
	logic [NOW_W-1:0]         last_clock_q;
	logic [NOW_W-1:0]         last_rate_time_q;
	logic signed [ALT_W-1:0]  last_alt_q;
	logic                     first_q;
	logic signed [ALT_W-1:0]  ground_q;
	logic                     upd_p_q;
	logic                     start_p_q;
	logic                     stop_p_q;
	logic                     out_valid_q;

	logic                     accept;
	logic                     emit;
	logic [NOW_W-1:0]         delta;
	logic [NOW_W-1:0]         hold_rem_a;
	logic [NOW_W-1:0]         elapsed;
	logic                     est;
	logic signed [CMP_W-1:0]  rate_ext;
	logic signed [CMP_W-1:0]  rate_mag;
	logic signed [CMP_W-1:0]  climb_thr_s;
	logic signed [CMP_W-1:0]  jump_thr_s;
	logic signed [CMP_W-1:0]  land_thr_s;
	logic [ALT_W:0]           diff;
	logic [ALT_W:0]           diff_mag;

	phase_t                   phase_n;
	logic                     hold_active_n;
	logic [NOW_W-1:0]         hold_rem_n;
	logic                     start_n;
	logic                     stop_n;

	fpd_rate_req_t            req;
	fpd_rate_rsp_t            rsp;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign emit     = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	assign delta = now_ms - last_clock_q;

	always_comb begin
		hold_rem_a = hold_rem_q;
		if (hold_active_q && delta != '0) begin
			hold_rem_a = (delta >= hold_rem_q) ? '0 : hold_rem_q - delta;
		end
	end

	assign rate_ext    = CMP_W'(climb_rate_q);
	assign rate_mag    = rate_ext[CMP_W-1] ? -rate_ext : rate_ext;
	assign climb_thr_s = $signed(CMP_W'(climb_thr_q));
	assign jump_thr_s  = CMP_W'($signed(jump_thr_q));
	assign land_thr_s  = $signed(CMP_W'(land_thr_q));

	always_comb begin
		phase_n       = phase_q;
		hold_active_n = hold_active_q;
		hold_rem_n    = hold_rem_a;
		start_n       = 1'b0;
		stop_n        = 1'b0;
		case (phase_q)
			PH_WAIT: begin
				if (rate_ext > climb_thr_s) begin
					phase_n = PH_FLIGHT;
					start_n = 1'b1;
				end
			end
			PH_FLIGHT: begin
				if (rate_ext <= jump_thr_s) begin
					phase_n = PH_JUMP;
				end
			end
			PH_JUMP: begin
				if (rate_mag <= land_thr_s) begin
					phase_n       = PH_LANDED;
					hold_rem_n    = NOW_W'(landed_hold_q);
					hold_active_n = 1'b1;
				end
			end
			PH_LANDED: begin
				if (rate_ext <= jump_thr_s) begin
					phase_n       = PH_JUMP;
					hold_active_n = 1'b0;
				end else if (rate_mag >= climb_thr_s) begin
					phase_n       = PH_FLIGHT;
					hold_active_n = 1'b0;
				end else if (hold_active_q && hold_rem_a == '0) begin
					phase_n       = PH_WAIT;
					hold_active_n = 1'b0;
					stop_n        = 1'b1;
				end
			end
			default: begin
				phase_n = PH_WAIT;
			end
		endcase
	end

	assign elapsed  = now_ms - last_rate_time_q;
	assign est      = elapsed > NOW_W'(rate_int_q);
	assign diff     = (ALT_W + 1)'(altitude_ft) - (ALT_W + 1)'(last_alt_q);
	assign diff_mag = diff[ALT_W] ? (~diff + 1'b1) : diff;

	assign req.start   = accept && est && !first_q;
	assign req.neg     = diff[ALT_W];
	assign req.mag     = diff_mag[ALT_W-1:0];
	assign req.elapsed = elapsed;

	fpd_rate_unit u_rate (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			climb_thr_q   <= CLIMB_THR_RST;
			jump_thr_q    <= JUMP_THR_RST;
			land_thr_q    <= LAND_THR_RST;
			landed_hold_q <= LANDED_HOLD_RST;
			rate_int_q    <= RATE_INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLIMB_THR:     climb_thr_q   <= cfg_data[THR_W-1:0];
				CFG_JUMP_THR:      jump_thr_q    <= cfg_data[JUMP_W-1:0];
				CFG_LAND_THR:      land_thr_q    <= cfg_data[THR_W-1:0];
				CFG_LANDED_HOLD:   landed_hold_q <= cfg_data[MS_W-1:0];
				CFG_RATE_INTERVAL: rate_int_q    <= cfg_data[MS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			phase_q          <= PH_WAIT;
			climb_rate_q     <= '0;
			hold_active_q    <= 1'b0;
			hold_rem_q       <= '0;
			last_clock_q     <= '0;
			last_rate_time_q <= '0;
			last_alt_q       <= '0;
			first_q          <= 1'b1;
			ground_q         <= '0;
			upd_p_q          <= 1'b0;
			start_p_q        <= 1'b0;
			stop_p_q         <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_clock_q  <= now_ms;
						phase_q       <= phase_n;
						hold_active_q <= hold_active_n;
						hold_rem_q    <= hold_rem_n;
						start_p_q     <= start_n;
						stop_p_q      <= stop_n;
						upd_p_q       <= est;
						if (est) begin
							last_rate_time_q <= now_ms;
							last_alt_q       <= altitude_ft;
							first_q          <= 1'b0;
							if (first_q) begin
								climb_rate_q <= '0;
							end
						end
						if (phase_n == PH_WAIT) begin
							ground_q <= altitude_ft;
						end
						state_q <= (est && !first_q) ? S_CALC : S_EMIT;
					end
				end
				S_CALC: begin
					if (rsp.done) begin
						climb_rate_q <= rsp.rate;
						state_q      <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			phase              <= phase_q;
			climb_rate_fpm     <= climb_rate_q;
			rate_updated       <= upd_p_q;
			ground_altitude_ft <= ground_q;
			log_start          <= start_p_q;
			log_stop           <= stop_p_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/fpd_checker.sv
module fpd_checker import fpd_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [1:0]               phase,
	input logic signed [RATE_W-1:0] climb_rate_fpm,
	input logic                     rate_updated,
	input logic signed [ALT_W-1:0]  ground_altitude_ft,
	input logic                     log_start,
	input logic                     log_stop
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase)
			&& $stable(climb_rate_fpm) && $stable(rate_updated)
			&& $stable(ground_altitude_ft))
		else $error("stalled result changed");

	// one sample at a time
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a new result only after a sample was in work
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without sample");

	a_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && log_start |-> phase == PH_FLIGHT)
		else $error("log start outside in flight");

	a_stop_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && log_stop |-> phase == PH_WAIT && !log_start)
		else $error("log stop outside wait");

endmodule

bind flight_phase_detector fpd_checker u_fpd_checker (.*);

>>> tb/flight_phase_detector_test.sv
`timescale 1ns / 1ps

module flight_phase_detector_test import fpd_pkg::*;;

	localparam int     PHASE_COUNT     = 12;
	localparam int     ITEMS_PER_PHASE = 85;
	localparam int     STALL_LIMIT     = 5000;
	localparam int     HOLD_OFF_CYCLES = 400;
	localparam longint RATE_TOP        = 524287;
	localparam longint RATE_BOTTOM     = -524288;
	localparam longint ALT_TOP         = 65535;
	localparam longint ALT_BOTTOM      = -65536;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;

	typedef enum int {
		LEG_GROUND,
		LEG_CLIMB,
		LEG_FREEFALL,
		LEG_LANDED
	} flight_leg_t;

	typedef struct packed {
		logic [1:0]               phase;
		logic signed [RATE_W-1:0] rate;
		logic                     updated;
		logic signed [ALT_W-1:0]  ground;
		logic                     start;
		logic                     stop;
	} flight_result_t;

	typedef struct {
		logic [NOW_W-1:0]        now;
		logic signed [ALT_W-1:0] alt;
		bit                      typed;
		flight_result_t          res;
	} sample_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic [NOW_W-1:0]         now_ms;
	logic signed [ALT_W-1:0]  altitude_ft;
	logic                     out_valid;
	logic                     out_ready;
	logic [1:0]               phase;
	logic signed [RATE_W-1:0] climb_rate_fpm;
	logic                     rate_updated;
	logic signed [ALT_W-1:0]  ground_altitude_ft;
	logic                     log_start;
	logic                     log_stop;

	// detector settings as written
	logic [THR_W-1:0]         climb_thr;
	logic signed [JUMP_W-1:0] jump_thr;
	logic [THR_W-1:0]         land_thr;
	logic [MS_W-1:0]          hold_ms;
	logic [MS_W-1:0]          interval_ms;

	// detector state
	phase_t                   st_phase;
	logic signed [RATE_W-1:0] st_rate;
	logic                     hold_on;
	logic [NOW_W-1:0]         hold_left;
	logic [NOW_W-1:0]         last_clock_ms;
	logic [NOW_W-1:0]         last_rate_ms;
	logic signed [ALT_W-1:0]  last_alt;
	logic                     rate_primed;
	logic signed [ALT_W-1:0]  ground_alt;

	flight_result_t pending_results[$];
	int             mismatch_count = 0;
	int             stall_cycles = 0;
	bit             steady_tail = 1'b0;
	bit             hold_off_req = 1'b0;
	logic [NOW_W-1:0] gen_now;
	longint         gen_alt;

	sample_row_t directed_rows [14] = '{
		'{32'd0,     17'd500,     1'b1, '{PH_WAIT, 20'd0, 1'b0, 17'd500, 1'b0, 1'b0}},
		'{32'd10001, 17'h10000,   1'b1, '{PH_WAIT, 20'd0, 1'b1, 17'h10000, 1'b0, 1'b0}},
		'{32'd20002, 17'h0FFFF,   1'b1, '{PH_WAIT, RATE_MAX, 1'b1, 17'h0FFFF, 1'b0, 1'b0}},
		'{32'd30003, 17'h10000,   1'b1, '{PH_FLIGHT, RATE_MIN, 1'b1, 17'h0FFFF, 1'b1, 1'b0}},
		'{32'd30003, 17'h10000,   1'b0, '0},
		'{32'd40004, 17'h10000,   1'b0, '0},
		'{32'd40005, 17'h10000,   1'b0, '0},
		'{32'd50006, 17'h10000,   1'b0, '0},
		'{32'd80007, 17'h10000,   1'b0, '0},
		'{32'hFFFF_FFFF, 17'd0,   1'b0, '0},
		'{32'h0000_2711, 17'd2000, 1'b0, '0},
		'{32'h0000_2711, 17'd2000, 1'b0, '0},
		'{32'hAAAA_5555, 17'h0AAAA, 1'b0, '0},
		'{32'h5555_AAAA, 17'h15555, 1'b0, '0}
	};

	flight_phase_detector u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.now_ms             (now_ms),
		.altitude_ft        (altitude_ft),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.phase              (phase),
		.climb_rate_fpm     (climb_rate_fpm),
		.rate_updated       (rate_updated),
		.ground_altitude_ft (ground_altitude_ft),
		.log_start          (log_start),
		.log_stop           (log_stop)
	);

	always #1 clk = ~clk;

	function automatic flight_result_t predict_phase_result(input logic [NOW_W-1:0] now,
			input logic signed [ALT_W-1:0] alt);
		flight_result_t r;
		logic [NOW_W-1:0] delta;
		logic [NOW_W-1:0] elapsed;
		longint rate;
		longint mag;
		longint quot;
		r = '0;
		delta = now - last_clock_ms;
		rate = st_rate;
		mag = (rate < 0) ? -rate : rate;
		if (delta != 0) begin
			if (hold_on)
				hold_left = (delta >= hold_left) ? '0 : hold_left - delta;
			last_clock_ms = now;
		end
		case (st_phase)
		PH_WAIT: begin
			if (rate > longint'(climb_thr)) begin
				st_phase = PH_FLIGHT;
				r.start = 1'b1;
			end
		end
		PH_FLIGHT: begin
			if (rate <= longint'(jump_thr))
				st_phase = PH_JUMP;
		end
		PH_JUMP: begin
			if (mag <= longint'(land_thr)) begin
				st_phase = PH_LANDED;
				hold_left = NOW_W'(hold_ms);
				hold_on = 1'b1;
			end
		end
		default: begin
			if (rate <= longint'(jump_thr)) begin
				st_phase = PH_JUMP;
				hold_on = 1'b0;
			end else if (mag >= longint'(climb_thr)) begin
				st_phase = PH_FLIGHT;
				hold_on = 1'b0;
			end else if (hold_on && hold_left == 0) begin
				st_phase = PH_WAIT;
				hold_on = 1'b0;
				r.stop = 1'b1;
			end
		end
		endcase
		elapsed = now - last_rate_ms;
		if (elapsed > NOW_W'(interval_ms)) begin
			if (rate_primed) begin
				quot = (longint'(alt) - longint'(last_alt)) * longint'(RATE_SCALE_MS);
				quot = quot / longint'(elapsed);
				if (quot > RATE_TOP)
					quot = RATE_TOP;
				else if (quot < RATE_BOTTOM)
					quot = RATE_BOTTOM;
				st_rate = quot[RATE_W-1:0];
			end else begin
				rate_primed = 1'b1;
				st_rate = '0;
			end
			last_alt = alt;
			last_rate_ms = now;
			r.updated = 1'b1;
		end
		if (st_phase == PH_WAIT)
			ground_alt = alt;
		r.phase = st_phase;
		r.rate = st_rate;
		r.ground = ground_alt;
		return r;
	endfunction

	task automatic offer_sample(input logic [NOW_W-1:0] now, input logic signed [ALT_W-1:0] alt,
			input bit typed, input flight_result_t typed_res);
		flight_result_t predicted;
		@(negedge clk);
		if (!steady_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		now_ms      <= now;
		altitude_ft <= alt;
		do @(posedge clk); while (!in_ready);
		predicted = predict_phase_result(now, alt);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic drain_results;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
		CFG_CLIMB_THR:     climb_thr = data[THR_W-1:0];
		CFG_JUMP_THR:      jump_thr = data[JUMP_W-1:0];
		CFG_LAND_THR:      land_thr = data[THR_W-1:0];
		CFG_LANDED_HOLD:   hold_ms = data;
		CFG_RATE_INTERVAL: interval_ms = data;
		default: ;
		endcase
	endtask

	// mostly ground, climb, freefall, landed in order, with some broken legs and noise
	task automatic fly_profile(input int count);
		flight_leg_t leg;
		int          leg_steps;
		longint      target;
		longint      dt;
		leg = LEG_GROUND;
		while (count > 0) begin
			case (leg)
			LEG_CLIMB:    target = longint'(climb_thr) + 200 + $urandom_range(0, 2000);
			LEG_FREEFALL: target = longint'(jump_thr) - 200 - $urandom_range(0, 6000);
			default:      target = 0;
			endcase
			leg_steps = (leg == LEG_LANDED) ? $urandom_range(5, 8) : $urandom_range(2, 7);
			while (leg_steps > 0 && count > 0) begin
				if ($urandom_range(0, 11) == 0) begin
					offer_sample($urandom(), ALT_W'($urandom()), 1'b0, '0);
				end else begin
					if ($urandom_range(0, 3) == 0)
						dt = $urandom_range(0, interval_ms);
					else
						dt = longint'(interval_ms) + 1 + $urandom_range(0, interval_ms / 4);
					if (leg == LEG_LANDED)
						dt += hold_ms / 4;
					gen_now += NOW_W'(dt);
					gen_alt += (target * dt + ((target < 0) ? -59999 : 59999)) / 60000;
					if (gen_alt > ALT_TOP)
						gen_alt = ALT_TOP;
					else if (gen_alt < ALT_BOTTOM)
						gen_alt = ALT_BOTTOM;
					offer_sample(gen_now, ALT_W'(gen_alt), 1'b0, '0);
				end
				leg_steps--;
				count--;
			end
			if ($urandom_range(0, 3) != 0)
				leg = leg.next();
			else
				leg = flight_leg_t'($urandom_range(0, 3));
		end
	endtask

	// result check
	always @(posedge clk) begin
		flight_result_t want;
		flight_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{phase, climb_rate_fpm, rate_updated, ground_altitude_ft, log_start, log_stop};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result with nothing pending: phase %0d rate %0d ground %0d",
						got.phase, got.rate, got.ground);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: want phase %0d rate %0d upd %0b ",
							want.phase, want.rate, want.updated,
							"ground %0d start %0b stop %0b; got phase %0d rate %0d ",
							want.ground, want.start, want.stop, got.phase, got.rate,
							"upd %0b ground %0d start %0b stop %0b",
							got.updated, got.ground, got.start, got.stop);
				end
			end
		end
	end

	// watchdog on transfers
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("flight_phase_detector_test: done, errors");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	// result side
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else if (!steady_tail && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		now_ms      = '0;
		altitude_ft = '0;
		climb_thr     = CLIMB_THR_RST;
		jump_thr      = JUMP_THR_RST;
		land_thr      = LAND_THR_RST;
		hold_ms       = LANDED_HOLD_RST;
		interval_ms   = RATE_INTERVAL_RST;
		st_phase      = PH_WAIT;
		st_rate       = '0;
		hold_on       = 1'b0;
		hold_left     = '0;
		last_clock_ms = '0;
		last_rate_ms  = '0;
		last_alt      = '0;
		rate_primed   = 1'b0;
		ground_alt    = '0;
		gen_alt       = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer_sample(directed_rows[i].now, directed_rows[i].alt,
				directed_rows[i].typed, directed_rows[i].res);
		gen_now = directed_rows[13].now;

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			drain_results();
			case (ph)
			0: begin
				write_reg(CFG_CLIMB_THR, '0);
				write_reg(CFG_JUMP_THR, '0);
				write_reg(CFG_LAND_THR, '0);
				write_reg(CFG_LANDED_HOLD, '0);
				write_reg(CFG_RATE_INTERVAL, '0);
			end
			1: begin
				write_reg(CFG_CLIMB_THR, CFG_DATA_W'(16'hFFFF));
				write_reg(CFG_JUMP_THR, CFG_DATA_W'(-65536));
				write_reg(CFG_LAND_THR, CFG_DATA_W'(16'hFFFF));
				write_reg(CFG_LANDED_HOLD, CFG_DATA_W'(1000000));
				write_reg(CFG_RATE_INTERVAL, CFG_DATA_W'(1000000));
			end
			2: begin
				for (int k = CFG_SPARE_FIRST; k < 2 ** CFG_IDX_W; k++)
					write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom()));
				write_reg(CFG_CLIMB_THR, CFG_DATA_W'(CLIMB_THR_RST));
				write_reg(CFG_JUMP_THR, CFG_DATA_W'(-2000));
				write_reg(CFG_LAND_THR, CFG_DATA_W'(LAND_THR_RST));
				write_reg(CFG_LANDED_HOLD, '0);
				write_reg(CFG_RATE_INTERVAL, '0);
			end
			default: begin
				if (ph % 4 == 3) begin
					write_reg(CFG_CLIMB_THR, CFG_DATA_W'($urandom_range(0, 65535)));
					write_reg(CFG_JUMP_THR, CFG_DATA_W'(-int'($urandom_range(0, 65536))));
					write_reg(CFG_LAND_THR, CFG_DATA_W'($urandom_range(0, 65535)));
					write_reg(CFG_LANDED_HOLD, CFG_DATA_W'($urandom_range(0, 1000000)));
					write_reg(CFG_RATE_INTERVAL, CFG_DATA_W'($urandom_range(1, 1000000)));
				end else begin
					write_reg(CFG_CLIMB_THR, CFG_DATA_W'($urandom_range(0, 3000)));
					write_reg(CFG_JUMP_THR, CFG_DATA_W'(-int'($urandom_range(0, 8000))));
					write_reg(CFG_LAND_THR, CFG_DATA_W'($urandom_range(0, 600)));
					write_reg(CFG_LANDED_HOLD, CFG_DATA_W'($urandom_range(0, 60000)));
					write_reg(CFG_RATE_INTERVAL, CFG_DATA_W'($urandom_range(1, 20000)));
				end
			end
			endcase
			@(negedge clk);
			cfg_we <= 1'b0;
			if (ph == 3)
				hold_off_req = 1'b1;
			steady_tail = (ph == PHASE_COUNT - 1);
			// start the timestamp near its wrap point for the phase
			if (ph % 3 == 2)
				gen_now = 32'hFFFF_FFFF - $urandom_range(0, 200000);
			if (ph == 4) begin
				fly_profile(ITEMS_PER_PHASE / 2);
				drain_results();
				fly_profile(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
			end else
				fly_profile(ITEMS_PER_PHASE);
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("flight_phase_detector_test: done, clean");
		else
			$display("flight_phase_detector_test: done, errors");
		$finish;
	end

endmodule
